FILE: rtl/asf_pkg.sv
// Package for the greedy activity selection core: sizes, widths and shared types.
// Depends on nothing; every other file of the block imports it.
package asf_pkg;

    // Capacity of the activity store and the derived widths.
    localparam int MAX_ITEMS = 64;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int TIME_W    = 16;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [TIME_W-1:0] t_time;

    // One stored activity.
    typedef struct packed {
        t_time start_time;
        t_time finish_time;
    } t_ent;

    // One classified item as it travels from front to back.
    typedef struct packed {
        t_ent act;
        logic is_last;
        logic drop;
        logic ovf;
    } t_act;

endpackage

FILE: rtl/asf_if.sv
// Handshake interfaces of the activity selection core: input and result channels.
// Depends on asf_pkg for the field widths.
interface asf_in_if;
    import asf_pkg::*;

    logic  valid;
    logic  ready;
    t_time start_time;
    t_time finish_time;
    logic  is_last;

    modport source (output valid, output start_time, output finish_time, output is_last,
                    input ready);
    modport sink (input valid, input start_time, input finish_time, input is_last,
                  output ready);
endinterface

interface asf_out_if;
    import asf_pkg::*;

    logic  valid;
    logic  ready;
    t_time chosen_start;
    t_time chosen_finish;
    logic  last_chosen;
    logic  overflowed;

    modport source (output valid, output chosen_start, output chosen_finish,
                    output last_chosen, output overflowed, input ready);
    modport sink (input valid, input chosen_start, input chosen_finish,
                  input last_chosen, input overflowed, output ready);
endinterface

FILE: rtl/asf_front.sv
// Front part: accepts activities, counts the set and marks items beyond capacity.
// Depends on asf_pkg and asf_if; feeds asf_queue.
module asf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    asf_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output asf_pkg::t_act o_item
);
    import asf_pkg::*;

    t_cnt r_cnt;
    t_cnt n_cnt;
    logic r_ovf;
    logic n_ovf;
    logic w_drop;

    // An item is taken whenever the queue has room.
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // The store is full once the set holds MAX_ITEMS activities.
    assign w_drop = (r_cnt == t_cnt'(MAX_ITEMS));

    always_comb begin
        o_item.act.start_time  = i_in.start_time;
        o_item.act.finish_time = i_in.finish_time;
        o_item.is_last         = i_in.is_last;
        o_item.drop            = w_drop;
        o_item.ovf             = r_ovf | w_drop;
    end

    // Set bookkeeping: the closing item starts a fresh set.
    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (o_push) begin
            if (i_in.is_last) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else begin
                n_ovf = r_ovf | w_drop;
                if (!w_drop) begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

endmodule

FILE: rtl/asf_queue.sv
// Short first-in first-out queue that decouples the front from the back.
// Depends on asf_pkg for the item type and depth.
module asf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  asf_pkg::t_act i_item,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output asf_pkg::t_act o_item
);
    import asf_pkg::*;

    t_act                r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_fill;

    assign o_valid = (r_fill != '0);
    assign o_full  = (r_fill == Q_CNT_W'(Q_DEPTH));
    assign o_item  = r_buf[r_rd_ptr];

    // Storage needs no reset; only the pointers are control state.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + Q_CNT_W'(1);
                2'b01:   r_fill <= r_fill - Q_CNT_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/asf_back.sv
// Back part: keeps the store sorted by finish time through insertion, then runs
// the greedy selection pass. Depends on asf_pkg and asf_if; fed by asf_queue.
module asf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  asf_pkg::t_act i_q_item,
    output logic          o_pop,
    asf_out_if.source     o_out
);
    import asf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_SELST = 3'd3;
    localparam logic [2:0] S_SEL   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    // Activity store, one write and one registered read per cycle.
    t_ent r_mem [MAX_ITEMS];
    t_ent r_rd;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cnt       r_cnt;
    t_cnt       n_cnt;
    t_idx       r_j;
    t_idx       n_j;
    t_idx       r_idx;
    t_idx       n_idx;
    t_ent       r_new;
    t_ent       n_new;
    logic       r_last;
    logic       n_last;
    logic       r_ovf;
    logic       n_ovf;
    t_ent       r_pend;
    t_ent       n_pend;

    logic       r_out_valid;
    t_ent       r_out_act;
    logic       r_out_last;
    logic       r_out_ovf;

    logic       w_wr_en;
    t_idx       w_wr_addr;
    t_ent       w_wr_data;
    logic       w_rd_en;
    t_idx       w_rd_addr;
    logic       w_load;
    logic       w_load_last;
    logic       w_slot_free;
    logic       w_sel;
    logic       w_end;

    assign w_slot_free = !r_out_valid || o_out.ready;

    // A candidate is chosen if it is the first, or starts no earlier than the
    // finish of the activity last chosen.
    assign w_sel = (r_idx == '0) || (r_rd.start_time >= r_pend.finish_time);
    assign w_end = ({1'b0, r_idx} == (r_cnt - t_cnt'(1)));

    // Sequencer for insertion and selection.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_j         = r_j;
        n_idx       = r_idx;
        n_new       = r_new;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_pend      = r_pend;
        o_pop       = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_j;
        w_wr_data   = r_new;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_load      = 1'b0;
        w_load_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_new  = i_q_item.act;
                    n_last = i_q_item.is_last;
                    n_ovf  = i_q_item.ovf;
                    if (i_q_item.drop) begin
                        n_state = i_q_item.is_last ? S_SELST : S_IDLE;
                    end else if (r_cnt == '0) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = i_q_item.act;
                        n_cnt     = t_cnt'(1);
                        n_state   = i_q_item.is_last ? S_SELST : S_IDLE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_cnt[IDX_W-1:0] - t_idx'(1);
                        n_j       = r_cnt[IDX_W-1:0];
                        n_state   = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                w_wr_en = 1'b1;
                if (r_rd.finish_time > r_new.finish_time) begin
                    // Move the larger entry up one place and look further down.
                    w_wr_data = r_rd;
                    n_j       = r_j - t_idx'(1);
                    if (r_j == t_idx'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_j - t_idx'(2);
                    end
                end else begin
                    n_cnt   = r_cnt + t_cnt'(1);
                    n_state = r_last ? S_SELST : S_IDLE;
                end
            end
            S_PLACE: begin
                w_wr_en = 1'b1;
                n_cnt   = r_cnt + t_cnt'(1);
                n_state = r_last ? S_SELST : S_IDLE;
            end
            S_SELST: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    w_rd_en = 1'b1;
                    n_idx   = '0;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                // A newly chosen entry releases the one chosen before it.
                if (!(w_sel && r_idx != '0) || w_slot_free) begin
                    if (w_sel) begin
                        n_pend = r_rd;
                    end
                    w_load = w_sel && (r_idx != '0);
                    if (w_end) begin
                        n_state = S_FLUSH;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx + t_idx'(1);
                        n_idx     = r_idx + t_idx'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (w_slot_free) begin
                    w_load      = 1'b1;
                    w_load_last = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_idx  <= n_idx;
        r_new  <= n_new;
        r_last <= n_last;
        r_ovf  <= n_ovf;
        r_pend <= n_pend;
        if (w_load) begin
            r_out_act  <= r_pend;
            r_out_last <= w_load_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.chosen_start  = r_out_act.start_time;
    assign o_out.chosen_finish = r_out_act.finish_time;
    assign o_out.last_chosen   = r_out_last;
    assign o_out.overflowed    = r_out_ovf;

`ifndef SYNTH
    // The store never holds more than its capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(MAX_ITEMS))
        else $error("activity count beyond capacity");

    // An insertion walk always points above the bottom entry and no further than one past the filled part.
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_j != '0 && {1'b0, r_j} <= r_cnt))
        else $error("insertion index out of range");

    // A result is never loaded over one that is still waiting.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_slot_free)
        else $error("result register overrun");

    // Closing a set empties the store.
    a_set_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && w_slot_free) |=> (r_cnt == '0 && r_state == S_IDLE))
        else $error("store not cleared after the set closed");
`endif

endmodule

FILE: rtl/activity_selection_by_finish_core.sv
// Greedy activity selection core. Activities are taken one a cycle while the front queue
// has room; the back inserts each stored activity by walking the store down from the top
// through one memory read and one write port per cycle, until it meets an entry that
// finishes no later; the first activity of a set goes straight in, a dropped one is discarded.
// After the closing activity, the selection pass reads the sorted store in order and holds
// each chosen activity until the next one is chosen or the pass ends; output stalls hold it.
// Synchronous active-low reset empties the queue and store count; no clearing pass.
module activity_selection_by_finish_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asf_in_if.sink    i_in,
    asf_out_if.source o_out
);
    import asf_pkg::*;

    logic w_push;
    t_act w_push_item;
    logic w_q_full;
    logic w_q_valid;
    t_act w_q_item;
    logic w_pop;

    // Acceptance and classification.
    asf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // Decoupling queue.
    asf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    // Sorted store and selection.
    asf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

FILE: tb/sv/tb_activity_selection_by_finish_core.sv
// Self-checking testbench for the greedy activity selection core: drives activity items,
// predicts the chosen activities of each set and checks every result item in order.
// Depends on asf_pkg, the asf_in_if and asf_out_if interfaces and the core itself.
module tb_activity_selection_by_finish_core;
    import asf_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 150;
    localparam int TARGET_ITEMS = 460;

    // One expected result item.
    typedef struct packed {
        t_time chosen_start;
        t_time chosen_finish;
        logic  last_chosen;
        logic  overflowed;
    } t_choice;

    logic i_clk = 1'b0;
    logic i_rst_n;

    asf_in_if  act_if ();
    asf_out_if sel_if ();

    activity_selection_by_finish_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (act_if),
        .o_out   (sel_if)
    );

    // Predictor state: the activities of the open set and its overflow flag.
    t_time   held_start [MAX_ITEMS];
    t_time   held_finish[MAX_ITEMS];
    int      held_count = 0;
    logic    held_ovf = 1'b0;
    t_choice choice_q[$];
    t_choice want;

    // Run statistics and idling controls.
    int   error_count = 0;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   sets_closed = 0;
    int   sets_overflowed = 0;
    int   choices_checked = 0;
    int   ready_hold = 0;
    logic src_gaps = 1'b0;
    logic sink_stalls = 1'b0;

    // Clock with a period of ten time units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pause length: mostly none or short, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Store one activity; on the closing item, sort stably by finish time and pick greedily.
    function automatic void take_activity(input t_time s, input t_time f, input logic last);
        t_time   ss[MAX_ITEMS];
        t_time   ff[MAX_ITEMS];
        t_time   ks;
        t_time   kf;
        int      i;
        int      j;
        int      prev;
        int      picks[$];
        t_choice c;
        if (held_count < MAX_ITEMS) begin
            held_start[held_count]  = s;
            held_finish[held_count] = f;
            held_count++;
        end else begin
            held_ovf = 1'b1;
        end
        if (!last) return;

        for (i = 0; i < held_count; i++) begin
            ss[i] = held_start[i];
            ff[i] = held_finish[i];
        end
        // Insertion sort moves an entry only past strictly later finishes, so ties keep order.
        for (i = 1; i < held_count; i++) begin
            ks = ss[i];
            kf = ff[i];
            j  = i;
            while (j > 0 && ff[j-1] > kf) begin
                ff[j] = ff[j-1];
                ss[j] = ss[j-1];
                j--;
            end
            ff[j] = kf;
            ss[j] = ks;
        end
        // Greedy pass: the first entry, then each one starting no earlier than the last finish.
        if (held_count > 0) begin
            picks.push_back(0);
            prev = 0;
            for (j = 1; j < held_count; j++) begin
                if (ss[j] >= ff[prev]) begin
                    picks.push_back(j);
                    prev = j;
                end
            end
        end
        for (i = 0; i < picks.size(); i++) begin
            c.chosen_start  = ss[picks[i]];
            c.chosen_finish = ff[picks[i]];
            c.last_chosen   = (i == picks.size() - 1);
            c.overflowed    = held_ovf;
            choice_q.push_back(c);
        end
        sets_closed++;
        if (held_ovf) sets_overflowed++;
        held_count = 0;
        held_ovf   = 1'b0;
    endfunction

    // Every accepted activity item feeds the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && act_if.valid && act_if.ready) begin
            take_activity(act_if.start_time, act_if.finish_time, act_if.is_last);
        end
    end

    // Every accepted result item is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && sel_if.valid && sel_if.ready) begin
            if (choice_q.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                          sel_if.chosen_start, sel_if.chosen_finish));
            end else begin
                want = choice_q.pop_front();
                choices_checked++;
                if (sel_if.chosen_start !== want.chosen_start)
                    report_mismatch($sformatf("chosen_start got %0d want %0d",
                                              sel_if.chosen_start, want.chosen_start));
                if (sel_if.chosen_finish !== want.chosen_finish)
                    report_mismatch($sformatf("chosen_finish got %0d want %0d",
                                              sel_if.chosen_finish, want.chosen_finish));
                if (sel_if.last_chosen !== want.last_chosen)
                    report_mismatch($sformatf("last_chosen got %b want %b",
                                              sel_if.last_chosen, want.last_chosen));
                if (sel_if.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed got %b want %b",
                                              sel_if.overflowed, want.overflowed));
            end
        end
    end

    // Result side back-pressure: random stalls while enabled, otherwise always ready.
    always @(posedge i_clk) begin
        if (!i_rst_n || !sink_stalls) begin
            sel_if.ready <= 1'b1;
            ready_hold   <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (sel_if.ready) begin
            ready_hold <= pause_len();
            if (ready_hold == 0 && $urandom_range(0, 1) == 1) sel_if.ready <= 1'b0;
        end else begin
            sel_if.ready <= 1'b1;
            ready_hold   <= $urandom_range(0, 6);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, choice_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Send one activity item; valid stays high unless a gap is inserted before the next.
    task automatic send_activity(input t_time s, input t_time f, input logic last);
        int gap;
        gap = src_gaps ? pause_len() : 0;
        if (gap > 0) begin
            act_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        act_if.valid       <= 1'b1;
        act_if.start_time  <= s;
        act_if.finish_time <= f;
        act_if.is_last     <= last;
        @(posedge i_clk);
        while (!act_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Random activity: mostly short, well-formed intervals on a narrow time range so that
    // many overlap and tie; the rest spans the full range, the top end or the extremes.
    task automatic random_activity(output t_time s, output t_time f);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            s = t_time'($urandom_range(0, 200));
            f = s + t_time'($urandom_range(0, 30));
        end else if (r < 82) begin
            s = t_time'($urandom_range(0, 65535));
            f = t_time'($urandom_range(0, 65535));
        end else if (r < 94) begin
            s = t_time'(65535 - $urandom_range(0, 300));
            f = t_time'(65535 - $urandom_range(0, 150));
        end else begin
            s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            f = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
    endtask

    task automatic random_set(input int n);
        t_time s;
        t_time f;
        int    k;
        for (k = 0; k < n; k++) begin
            random_activity(s, f);
            send_activity(s, f, k == n - 1);
        end
    endtask

    // Sets of one activity at both ends of the time range.
    task automatic test_single_activity();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_activity(16'hFFFF, 16'hFFFF, 1'b1);
        send_activity(16'h0000, 16'h0000, 1'b1);
        send_activity(16'h0000, 16'hFFFF, 1'b1);
    endtask

    // Extreme, reversed and zero-length activities judged by the same comparisons.
    task automatic test_extremes_and_reversed();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_activity(16'h0000, 16'hFFFF, 1'b0);
        send_activity(16'hFFFF, 16'h0000, 1'b0);
        send_activity(16'd100,  16'd100,  1'b0);
        send_activity(16'h0000, 16'h0000, 1'b0);
        send_activity(16'h0000, 16'h0000, 1'b0);
        send_activity(16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    // Equal finish times must keep their arrival order.
    task automatic test_equal_finish_order();
        src_gaps    = 1'b0;
        sink_stalls = 1'b1;
        send_activity(16'd5,  16'd10, 1'b0);
        send_activity(16'd3,  16'd10, 1'b0);
        send_activity(16'd7,  16'd10, 1'b0);
        send_activity(16'd12, 16'd20, 1'b0);
        send_activity(16'd10, 16'd20, 1'b1);
    endtask

    // A chain of touching activities arriving out of order is chosen entirely.
    task automatic test_touching_chain();
        src_gaps    = 1'b1;
        sink_stalls = 1'b0;
        send_activity(16'd2, 16'd3, 1'b0);
        send_activity(16'd0, 16'd1, 1'b0);
        send_activity(16'd3, 16'd9, 1'b0);
        send_activity(16'd1, 16'd2, 1'b1);
    endtask

    // Full store, overflow with the closing item dropped, then a set showing the flag cleared.
    task automatic test_store_overflow();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        random_set(MAX_ITEMS);
        random_set(MAX_ITEMS + 1);
        random_set(MAX_ITEMS + 5);
        random_set(3);
    endtask

    // Random sets, mostly small, some mid-sized and a few near or past capacity.
    task automatic test_random_sets();
        int r;
        int n;
        while (items_sent < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80)      n = $urandom_range(1, 10);
            else if (r < 95) n = $urandom_range(11, 40);
            else             n = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 4);
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            random_set(n);
        end
    endtask

    // Main sequence: reset, directed tests, random sets, then drain and verdict.
    initial begin
        i_rst_n            <= 1'b0;
        act_if.valid       <= 1'b0;
        act_if.start_time  <= '0;
        act_if.finish_time <= '0;
        act_if.is_last     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_activity();
        test_extremes_and_reversed();
        test_equal_finish_order();
        test_touching_chain();
        test_store_overflow();
        test_random_sets();

        act_if.valid <= 1'b0;
        while (choice_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d activities in %0d sets (%0d overflowed); checked %0d chosen items.",
                 items_sent, sets_closed, sets_overflowed, choices_checked);
        $display("Mismatches: %0d, cycles: %0d.", error_count, cycle_count);
        if (error_count == 0 && choice_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
